// File: hw/rtl/crtp_pkg.sv
// ----------------------------------------------------------------------------
// crtp_pkg: shared widths and constants for the circumradius pipeline
// Fixed-point formats, split points for partial products, clamp limits.
// ----------------------------------------------------------------------------
`default_nettype none
package crtp_pkg;

  localparam int CW    = 24;             // coordinate width, signed
  localparam int FB    = 12;             // fraction bits
  localparam int DIFW  = CW + 2;         // 2*(p - q)
  localparam int SQW   = 2 * CW;         // coordinate squared
  localparam int SUMW  = 2 * CW + 2;     // c, f
  localparam int PRODW = 2 * DIFW;       // b*d, e*a, den
  localparam int FL    = SUMW / 2;       // low part of c/f, unsigned
  localparam int FH    = SUMW - FL;      // high part of c/f, signed
  localparam int PPW   = DIFW + FL + 1;  // diff times c/f part
  localparam int NW    = DIFW + SUMW + 2;// nx, ny
  localparam int DL    = PRODW / 2;      // low part of den / |den|
  localparam int DH    = PRODW - DL;
  localparam int XPW   = CW + DL + 1;    // coordinate times den part
  localparam int PW    = NW + 2;         // px, py
  localparam int QW    = 32;             // quotient bits
  localparam int LPW   = QW + DL;        // RMAX times |den| part
  localparam int DW    = PRODW + QW;     // divider remainder / limit
  localparam int SSW   = 2 * QW + 1;     // qx^2 + qy^2
  localparam int RW    = QW + 1;         // square root bits
  localparam int TW    = 2 * RW + 1;     // square root remainder
  localparam int OW    = 32;             // radius width

  localparam logic [OW-1:0] RMAX_RAW = OW'(64'd1000000 << FB);
  localparam logic [OW-1:0] RMIN_RAW = OW'(64'd1 << FB);

  typedef struct packed {
    logic degen;  // den zero
    logic big;    // centre offset in x or y at or over the upper clamp
    logic right;  // centre x positive
  } side_t;

endpackage
`default_nettype wire

// File: hw/rtl/circumradius_three_points.sv
// ----------------------------------------------------------------------------
// circumradius_three_points: circumradius of three planar points
// Exact integer bisector solve, pipelined restoring divide and square root,
// clamp to 1.0 .. 1e6 with a centre-side bit and a collinear flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+-----------------------------------------
//  points  | pts_valid / pts_ready | ax, ay, bx, by_coord, cx, cy
//  result  | res_valid / res_ready | radius, centre_right, degenerate
//
//  One transaction per cycle while the skid register is empty. 75 register
//  stages (9 arithmetic, 32 divide, 33 square-root, one output). The divider
//  and square root retire one bit per stage, which sets depth.
//  Reset clears valid bits only; payload registers are not reset.
//  The whole pipe holds when the output skid register is full; a result
//  waiting in the output register does not stop new points entering.
//
`default_nettype none
module circumradius_three_points (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          pts_valid,
  output logic                               pts_ready,
  input  wire logic signed [crtp_pkg::CW-1:0] ax,
  input  wire logic signed [crtp_pkg::CW-1:0] ay,
  input  wire logic signed [crtp_pkg::CW-1:0] bx,
  input  wire logic signed [crtp_pkg::CW-1:0] by_coord,
  input  wire logic signed [crtp_pkg::CW-1:0] cx,
  input  wire logic signed [crtp_pkg::CW-1:0] cy,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output logic [crtp_pkg::OW-1:0]            radius,
  output logic                               centre_right,
  output logic                               degenerate
);
  import crtp_pkg::*;

  logic s_v;  // skid register holds a result
  logic en;   // pipeline advance
  assign en = !s_v;
  assign pts_ready = en;

  // ---------------- stage 1: differences and squares ----------------
  logic              v1;
  logic signed [DIFW-1:0] r1_a, r1_b, r1_d, r1_e;
  logic signed [CW-1:0]   r1_x1, r1_y1;
  logic signed [SQW-1:0]  r1_sx1, r1_sy1, r1_sx2, r1_sy2, r1_sx3, r1_sy3;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= pts_valid;
    if (en) begin
      r1_a   <= (DIFW'(bx) - DIFW'(ax)) <<< 1;
      r1_b   <= (DIFW'(by_coord) - DIFW'(ay)) <<< 1;
      r1_d   <= (DIFW'(cx) - DIFW'(bx)) <<< 1;
      r1_e   <= (DIFW'(cy) - DIFW'(by_coord)) <<< 1;
      r1_x1  <= ax;
      r1_y1  <= ay;
      r1_sx1 <= ax * ax;
      r1_sy1 <= ay * ay;
      r1_sx2 <= bx * bx;
      r1_sy2 <= by_coord * by_coord;
      r1_sx3 <= cx * cx;
      r1_sy3 <= cy * cy;
    end
  end

  // ---------------- stage 2: c, f and denominator products ----------------
  logic              v2;
  logic signed [DIFW-1:0]  r2_a, r2_b, r2_d, r2_e;
  logic signed [CW-1:0]    r2_x1, r2_y1;
  logic signed [SUMW-1:0]  r2_c, r2_f;
  logic signed [PRODW-1:0] r2_bd, r2_ea;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      r2_a  <= r1_a;
      r2_b  <= r1_b;
      r2_d  <= r1_d;
      r2_e  <= r1_e;
      r2_x1 <= r1_x1;
      r2_y1 <= r1_y1;
      r2_c  <= SUMW'(r1_sx2) + SUMW'(r1_sy2) - SUMW'(r1_sx1) - SUMW'(r1_sy1);
      r2_f  <= SUMW'(r1_sx3) + SUMW'(r1_sy3) - SUMW'(r1_sx2) - SUMW'(r1_sy2);
      r2_bd <= PRODW'(r1_b) * PRODW'(r1_d);
      r2_ea <= PRODW'(r1_e) * PRODW'(r1_a);
    end
  end

  // ---------------- stage 3: den, numerator partial products ----------------
  logic signed [FL:0]   c_lo, f_lo;   // zero-extended low halves
  logic signed [FH-1:0] c_hi, f_hi;
  assign c_lo = $signed({1'b0, r2_c[FL-1:0]});
  assign f_lo = $signed({1'b0, r2_f[FL-1:0]});
  assign c_hi = r2_c[SUMW-1:FL];
  assign f_hi = r2_f[SUMW-1:FL];

  logic              v3;
  logic signed [CW-1:0]    r3_x1, r3_y1;
  logic signed [PRODW-1:0] r3_den;
  logic signed [PPW-1:0]   r3_bfl, r3_bfh, r3_ecl, r3_ech;
  logic signed [PPW-1:0]   r3_dcl, r3_dch, r3_afl, r3_afh;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      r3_x1  <= r2_x1;
      r3_y1  <= r2_y1;
      r3_den <= r2_bd - r2_ea;
      r3_bfl <= PPW'(r2_b) * PPW'(f_lo);
      r3_bfh <= PPW'(r2_b) * PPW'(f_hi);
      r3_ecl <= PPW'(r2_e) * PPW'(c_lo);
      r3_ech <= PPW'(r2_e) * PPW'(c_hi);
      r3_dcl <= PPW'(r2_d) * PPW'(c_lo);
      r3_dch <= PPW'(r2_d) * PPW'(c_hi);
      r3_afl <= PPW'(r2_a) * PPW'(f_lo);
      r3_afh <= PPW'(r2_a) * PPW'(f_hi);
    end
  end

  // ---------------- stage 4: nx, ny, x1*den and y1*den parts, |den| --------
  logic signed [DL:0]   den_lo;
  logic signed [DH-1:0] den_hi;
  assign den_lo = $signed({1'b0, r3_den[DL-1:0]});
  assign den_hi = r3_den[PRODW-1:DL];

  logic              v4;
  logic signed [NW-1:0]  r4_nx, r4_ny;
  logic signed [XPW-1:0] r4_xdl, r4_xdh, r4_ydl, r4_ydh;
  logic [PRODW-1:0]      r4_ad;
  logic                  r4_dz, r4_dn;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      r4_nx  <= ((NW'(r3_bfh) <<< FL) + NW'(r3_bfl)) - ((NW'(r3_ech) <<< FL) + NW'(r3_ecl));
      r4_ny  <= ((NW'(r3_dch) <<< FL) + NW'(r3_dcl)) - ((NW'(r3_afh) <<< FL) + NW'(r3_afl));
      r4_xdl <= XPW'(r3_x1) * XPW'(den_lo);
      r4_xdh <= XPW'(r3_x1) * XPW'(den_hi);
      r4_ydl <= XPW'(r3_y1) * XPW'(den_lo);
      r4_ydh <= XPW'(r3_y1) * XPW'(den_hi);
      r4_ad  <= r3_den[PRODW-1] ? PRODW'(-r3_den) : PRODW'(r3_den);
      r4_dz  <= (r3_den == '0);
      r4_dn  <= r3_den[PRODW-1];
    end
  end

  // ---------------- stage 5: px, py, limit parts, centre side ----------------
  logic right5;
  always_comb begin
    if (r4_dz) right5 = !r4_nx[NW-1] && (r4_nx != '0);
    else       right5 = (r4_nx != '0) && (r4_nx[NW-1] == r4_dn);
  end

  logic              v5;
  logic signed [PW-1:0] r5_px, r5_py;
  logic [LPW-1:0]       r5_lml, r5_lmh;
  logic [PRODW-1:0]     r5_ad;
  side_t                r5_side;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
    if (en) begin
      r5_px   <= PW'(r4_nx) - ((PW'(r4_xdh) <<< DL) + PW'(r4_xdl));
      r5_py   <= PW'(r4_ny) - ((PW'(r4_ydh) <<< DL) + PW'(r4_ydl));
      r5_lml  <= LPW'(RMAX_RAW) * LPW'(r4_ad[DL-1:0]);
      r5_lmh  <= LPW'(RMAX_RAW) * LPW'(r4_ad[PRODW-1:DL]);
      r5_ad   <= r4_ad;
      r5_side <= '{degen: r4_dz, big: 1'b0, right: right5};
    end
  end

  // ---------------- stage 6: magnitudes and the full limit ----------------
  logic [PW-1:0] apx, apy;
  assign apx = r5_px[PW-1] ? PW'(-r5_px) : PW'(r5_px);
  assign apy = r5_py[PW-1] ? PW'(-r5_py) : PW'(r5_py);

  logic              v6;
  logic [DW-1:0]     r6_apx, r6_apy, r6_lim;
  logic [PRODW-1:0]  r6_ad;
  side_t             r6_side;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
    if (en) begin
      r6_apx  <= DW'(apx);
      r6_apy  <= DW'(apy);
      r6_lim  <= (DW'(r5_lmh) << DL) + DW'(r5_lml);
      r6_ad   <= r5_ad;
      r6_side <= r5_side;
    end
  end

  // ---------------- stage 7: large-circle test, divider input ----------------
  logic [DW-1:0]    dr_x [0:QW];
  logic [DW-1:0]    dr_y [0:QW];
  logic [QW-1:0]    dq_x [0:QW];
  logic [QW-1:0]    dq_y [0:QW];
  logic [PRODW-1:0] dd   [0:QW];
  side_t            ds   [0:QW];
  logic             dv   [0:QW];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= v6;
    if (en) begin
      dr_x[0] <= r6_apx;
      dr_y[0] <= r6_apy;
      dq_x[0] <= '0;
      dq_y[0] <= '0;
      dd[0]   <= r6_ad;
      ds[0]   <= '{degen: r6_side.degen,
                   big:   (r6_apx >= r6_lim) || (r6_apy >= r6_lim),
                   right: r6_side.right};
    end
  end

  // ---------------- restoring divide, one quotient bit per stage ----------
  // Quotient fits QW bits whenever the large-circle test is clear.
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [DW-1:0] sh;
    logic          gx, gy;
    assign sh = DW'(dd[k]) << (QW - 1 - k);
    assign gx = dr_x[k] >= sh;
    assign gy = dr_y[k] >= sh;

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        dr_x[k+1] <= gx ? dr_x[k] - sh : dr_x[k];
        dr_y[k+1] <= gy ? dr_y[k] - sh : dr_y[k];
        dq_x[k+1] <= {dq_x[k][QW-2:0], gx};
        dq_y[k+1] <= {dq_y[k][QW-2:0], gy};
        dd[k+1]   <= dd[k];
        ds[k+1]   <= ds[k];
      end
    end
  end

  // ---------------- stage 8: squares of the quotients ----------------
  logic              v8;
  logic [2*QW-1:0]   r8_sqx, r8_sqy;
  side_t             r8_side;

  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else if (en) v8 <= dv[QW];
    if (en) begin
      r8_sqx  <= dq_x[QW] * dq_x[QW];
      r8_sqy  <= dq_y[QW] * dq_y[QW];
      r8_side <= ds[QW];
    end
  end

  // ---------------- stage 9: sum of squares, root input ----------------
  logic [TW-1:0] sr_rem [0:RW];
  logic [RW-1:0] sr_res [0:RW];
  side_t         sr_sd  [0:RW];
  logic          sr_v   [0:RW];

  always_ff @(posedge clk) begin
    if (rst) sr_v[0] <= 1'b0;
    else if (en) sr_v[0] <= v8;
    if (en) begin
      sr_rem[0] <= TW'(SSW'(r8_sqx) + SSW'(r8_sqy));
      sr_res[0] <= '0;
      sr_sd[0]  <= r8_side;
    end
  end

  // ---------------- integer square root, one root bit per stage ----------
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    localparam int BI = RW - 1 - k;
    logic [TW-1:0] t;
    logic          ge;
    assign t  = (TW'(sr_res[k]) << (BI + 1)) | (TW'(1) << (2 * BI));
    assign ge = sr_rem[k] >= t;

    always_ff @(posedge clk) begin
      if (rst) sr_v[k+1] <= 1'b0;
      else if (en) sr_v[k+1] <= sr_v[k];
      if (en) begin
        sr_rem[k+1] <= ge ? sr_rem[k] - t : sr_rem[k];
        sr_res[k+1] <= ge ? (sr_res[k] | (RW'(1) << BI)) : sr_res[k];
        sr_sd[k+1]  <= sr_sd[k];
      end
    end
  end

  // ---------------- clamp ----------------
  logic [OW-1:0] rad;
  side_t         fsd;
  assign fsd = sr_sd[RW];
  always_comb begin
    if (fsd.degen || fsd.big || (sr_res[RW] > RW'(RMAX_RAW))) rad = RMAX_RAW;
    else if (sr_res[RW] < RW'(RMIN_RAW))                      rad = RMIN_RAW;
    else                                                      rad = OW'(sr_res[RW]);
  end

  // ---------------- output register plus skid ----------------
  logic [OW-1:0] s_rad;
  logic          s_right, s_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      s_v       <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (s_v) begin
        res_valid <= 1'b1;
        s_v       <= 1'b0;
      end else begin
        res_valid <= sr_v[RW];
      end
    end else if (sr_v[RW]) begin
      s_v <= 1'b1;  // skid fills, or stays full if it already held a result
    end

    if (!res_valid || res_ready) begin
      if (s_v) begin
        radius       <= s_rad;
        centre_right <= s_right;
        degenerate   <= s_deg;
      end else begin
        radius       <= rad;
        centre_right <= fsd.right;
        degenerate   <= fsd.degen;
      end
    end else if (!s_v) begin
      s_rad   <= rad;
      s_right <= fsd.right;
      s_deg   <= fsd.degen;
    end
  end

endmodule
`default_nettype wire
